// ----- rtl/dlpd_pkg.sv -----
// ----------------------------------------------------------------------------
// dlpd_pkg
// Shared types and constants for the decimal length prefix deframer.
// ----------------------------------------------------------------------------
package dlpd_pkg;

  localparam int unsigned MAX_STRING_LENGTH = 65535;
  localparam int unsigned LEN_W = $clog2(MAX_STRING_LENGTH + 1);
  localparam int unsigned ACC_W = LEN_W + 4;

  localparam logic [7:0] DIGIT_LO = 8'h30;
  localparam logic [7:0] DIGIT_HI = 8'h39;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_PAYLOAD = 2'd1,
    MODE_DROP    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_DIGITS = 2'd1,
    STATUS_TOO_LARGE = 2'd2,
    STATUS_TRUNCATED = 2'd3
  } status_t;

  typedef struct packed {
    mode_t            mode;
    logic [LEN_W-1:0] acc;
    logic             saw_digit;
    logic [LEN_W-1:0] bytes_left;
  } state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       string_end;
    status_t    status;
  } result_t;

endpackage

// ----- rtl/dlpd_step.sv -----
// ----------------------------------------------------------------------------
// dlpd_step
// Next-state and result logic for one request byte of the deframer.
// ----------------------------------------------------------------------------
module dlpd_step
  import dlpd_pkg::*;
(
  input  state_t     cur,
  input  logic [7:0] in_byte,
  input  logic       message_end,
  output state_t     nxt,
  output logic       emit,
  output result_t    res
);

  logic             is_digit;
  logic [ACC_W-1:0] acc_wide;
  logic [LEN_W-1:0] left_dec;

  always_comb begin
    is_digit = in_byte inside {[DIGIT_LO:DIGIT_HI]};
    acc_wide = (ACC_W'(cur.acc) << 3) + (ACC_W'(cur.acc) << 1) + ACC_W'(in_byte[3:0]);
    left_dec = (cur.bytes_left != '0) ? cur.bytes_left - LEN_W'(1) : '0;
  end

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    res  = '{data: 8'h00, byte_valid: 1'b0, string_end: 1'b0, status: STATUS_OK};
    case (cur.mode)
      MODE_HEADER: begin
        if (is_digit) begin
          nxt.saw_digit = 1'b1;
          if (acc_wide > ACC_W'(MAX_STRING_LENGTH)) begin
            emit   = 1'b1;
            res.status = STATUS_TOO_LARGE;
          end else if (message_end) begin
            emit   = 1'b1;
            res.status = STATUS_TRUNCATED;
          end else begin
            nxt.acc = acc_wide[LEN_W-1:0];
          end
        end else if (!cur.saw_digit) begin
          emit   = 1'b1;
          res.status = STATUS_NO_DIGITS;
        end else if (cur.acc == '0) begin
          nxt.saw_digit  = 1'b0;
          emit           = 1'b1;
          res.string_end = 1'b1;
        end else if (message_end) begin
          emit   = 1'b1;
          res.status = STATUS_TRUNCATED;
        end else begin
          nxt.bytes_left = cur.acc;
          nxt.acc        = '0;
          nxt.saw_digit  = 1'b0;
          nxt.mode       = MODE_PAYLOAD;
        end
        if (emit && res.status != STATUS_OK) begin
          nxt.acc        = '0;
          nxt.saw_digit  = 1'b0;
          nxt.bytes_left = '0;
          nxt.mode       = message_end ? MODE_HEADER : MODE_DROP;
        end
      end
      MODE_PAYLOAD: begin
        emit           = 1'b1;
        res.data       = in_byte;
        res.byte_valid = 1'b1;
        nxt.bytes_left = left_dec;
        if (left_dec == '0) begin
          nxt.mode       = MODE_HEADER;
          nxt.acc        = '0;
          nxt.saw_digit  = 1'b0;
          res.string_end = 1'b1;
        end else if (message_end) begin
          nxt.mode       = MODE_HEADER;
          nxt.acc        = '0;
          nxt.saw_digit  = 1'b0;
          nxt.bytes_left = '0;
          res.status     = STATUS_TRUNCATED;
        end
      end
      default: begin
        if (message_end) begin
          nxt.mode       = MODE_HEADER;
          nxt.acc        = '0;
          nxt.saw_digit  = 1'b0;
          nxt.bytes_left = '0;
        end
      end
    endcase
  end

endmodule

// ----- rtl/decimal_length_prefix_deframer.sv -----
// ----------------------------------------------------------------------------
// decimal_length_prefix_deframer
// Splits a byte stream of decimal-length-prefixed strings into payload bytes.
// ----------------------------------------------------------------------------
// Takes one message byte per clock and presents at most one result per byte:
// the byte sits in an input register, is decoded by one pass of small logic (a
// times-ten add and a compare on the 16-bit length, a decrement of the payload
// count) and lands in a result register. A new byte is taken every cycle while
// results are taken; a stalled result holds one byte in the input register
// before the block stops taking more. Length digits and dropped bytes give no
// result. Header errors give one result with no byte, then bytes are dropped
// until message_end; a cut payload's last byte has a truncated status.
module decimal_length_prefix_deframer
  import dlpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [7:0] in_byte,
  input  logic       message_end,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       string_end,
  output status_t    status
);

  logic       pend_valid;
  logic [7:0] pend_byte;
  logic       pend_end;
  state_t     st;
  state_t     st_next;
  logic       emit;
  result_t    res;
  result_t    out_reg;
  logic       out_free;
  logic       advance;

  assign out_free   = !result_valid || result_ready;
  assign advance    = pend_valid && out_free;
  assign item_ready = !pend_valid || out_free;

  dlpd_step u_step (
    .cur         (st),
    .in_byte     (pend_byte),
    .message_end (pend_end),
    .nxt         (st_next),
    .emit        (emit),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      st           <= '{mode: MODE_HEADER, acc: '0, saw_digit: 1'b0, bytes_left: '0};
    end else begin
      if (item_valid && item_ready) begin
        pend_valid <= 1'b1;
      end else if (advance) begin
        pend_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= emit;
        st           <= st_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      pend_byte <= in_byte;
      pend_end  <= message_end;
    end
    if (advance && emit) begin
      out_reg <= res;
    end
  end

  assign out_byte   = out_reg.data;
  assign byte_valid = out_reg.byte_valid;
  assign string_end = out_reg.string_end;
  assign status     = out_reg.status;

  a_payload_count : assert property (@(posedge clk) disable iff (rst)
    st.mode == MODE_PAYLOAD |-> st.bytes_left != '0)
    else $error("payload mode with no bytes left");

  a_acc_bound : assert property (@(posedge clk) disable iff (rst)
    st.acc <= LEN_W'(MAX_STRING_LENGTH))
    else $error("length accumulator above maximum");

  a_end_ok : assert property (@(posedge clk) disable iff (rst)
    result_valid && string_end |-> status == STATUS_OK)
    else $error("string end with error status");

  a_err_no_byte : assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == STATUS_NO_DIGITS || status == STATUS_TOO_LARGE)
      |-> !byte_valid && out_byte == 8'h00)
    else $error("header error result carries a byte");

endmodule

// ----- dv/decimal_length_prefix_deframer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_length_prefix_deframer_test
// Self-checking bench for the decimal length prefix deframer.
// ----------------------------------------------------------------------------
// Directed messages hit payload byte extremes, empty strings, leading zeros,
// missing and oversized lengths and messages cut short in the header and in
// the payload. Random messages then follow. Most are well formed, and a share
// of them are truncated, oversized, missing their digits or made of noise.
// A decoder in the bench tracks header, payload and drop modes for every
// accepted request and queues the expected result. Each accepted result is
// compared field by field against the oldest entry in that queue. Both
// handshakes idle at random, but for a last run of random messages with no idles.
// ----------------------------------------------------------------------------
module decimal_length_prefix_deframer_test;
  import dlpd_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  logic [7:0] in_byte = 8'h00;
  logic       message_end = 1'b0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_end;
  status_t    status;

  decimal_length_prefix_deframer u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .in_byte      (in_byte),
    .message_end  (message_end),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .string_end   (string_end),
    .status       (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mode_t            dec_mode = MODE_HEADER;
  logic [ACC_W-1:0] dec_len = '0;
  logic             dec_saw = 1'b0;
  logic [LEN_W-1:0] dec_left = '0;

  result_t     pending_results[$];
  int unsigned errors = 0;
  int unsigned requests_sent = 0;
  int unsigned stall_cycles = 0;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  int unsigned rx_hold = 0;

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b >= DIGIT_LO && b <= DIGIT_HI);
    return b;
  endfunction

  function automatic void clear_length();
    dec_len = '0;
    dec_saw = 1'b0;
  endfunction

  function automatic bit header_fault(input status_t st, input logic last,
                                      output result_t r);
    clear_length();
    dec_left = '0;
    if (last) dec_mode = MODE_HEADER;
    else dec_mode = MODE_DROP;
    r = '0;
    r.status = st;
    return 1'b1;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output result_t r);
    r = '0;
    case (dec_mode)
      MODE_HEADER: begin
        if (b >= DIGIT_LO && b <= DIGIT_HI) begin
          dec_len = ACC_W'(dec_len * 10 + (b - DIGIT_LO));
          dec_saw = 1'b1;
          if (dec_len > MAX_STRING_LENGTH) return header_fault(STATUS_TOO_LARGE, last, r);
          if (last) return header_fault(STATUS_TRUNCATED, last, r);
          return 1'b0;
        end
        if (!dec_saw) return header_fault(STATUS_NO_DIGITS, last, r);
        if (dec_len == 0) begin
          clear_length();
          r.string_end = 1'b1;
          return 1'b1;
        end
        if (last) return header_fault(STATUS_TRUNCATED, last, r);
        dec_left = dec_len[LEN_W-1:0];
        clear_length();
        dec_mode = MODE_PAYLOAD;
        return 1'b0;
      end
      MODE_PAYLOAD: begin
        if (dec_left != 0) dec_left = dec_left - 1'b1;
        r.data = b;
        r.byte_valid = 1'b1;
        if (dec_left == 0) begin
          dec_mode = MODE_HEADER;
          clear_length();
          r.string_end = 1'b1;
        end else if (last) begin
          dec_mode = MODE_HEADER;
          clear_length();
          dec_left = '0;
          r.status = STATUS_TRUNCATED;
        end
        return 1'b1;
      end
      default: begin
        if (last) begin
          dec_mode = MODE_HEADER;
          clear_length();
          dec_left = '0;
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    bit      has;
    if (rst) begin
      dec_mode = MODE_HEADER;
      clear_length();
      dec_left = '0;
      stall_cycles = 0;
    end else begin
      if (item_valid && item_ready) begin
        has = decode_byte(in_byte, message_end, want);
        if (has) pending_results = {pending_results, want};
      end
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result mismatch: expected none, actual %h/%b/%b/%0d", $time,
                   out_byte, byte_valid, string_end, status);
        end else begin
          want = pending_results.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid));
          check_field("string_end", 8'(want.string_end), 8'(string_end));
          check_field("status", 8'(want.status), 8'(status));
        end
      end
      if ((item_valid && item_ready) || (result_valid && result_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      result_ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      rx_hold <= idle_len() - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = idle_len();
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    in_byte     <= b;
    message_end <= last;
    do @(posedge clk); while (!item_ready);
    requests_sent++;
  endtask

  task automatic send_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], last && (i == s.len() - 1));
  endtask

  // hold off the sender until every expected result is back
  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_random_message();
    logic [7:0]  msg[$];
    string       hdr;
    int unsigned n_str, len, pick;
    n_str = $urandom_range(1, 4);
    for (int s = 0; s < n_str; s++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        msg = {msg, non_digit()};
      end else if (pick < 8) begin
        hdr = $sformatf("%0d", $urandom_range(MAX_STRING_LENGTH + 1, 9999999));
        for (int i = 0; i < hdr.len(); i++) msg = {msg, 8'(hdr[i])};
        msg = {msg, non_digit()};
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 15) len = 0;
        else if (pick < 85) len = $urandom_range(1, 8);
        else if (pick < 97) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 300);
        hdr = $sformatf("%0d", len);
        if ($urandom_range(0, 9) == 0) hdr = {"00", hdr};
        for (int i = 0; i < hdr.len(); i++) msg = {msg, 8'(hdr[i])};
        msg = {msg, non_digit()};
        repeat (len) msg = {msg, 8'($urandom_range(0, 255))};
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      msg = msg[0:$urandom_range(0, msg.size() - 1)];
    end else if (pick < 20) begin
      msg.delete();
      repeat ($urandom_range(1, 12)) msg = {msg, 8'($urandom_range(0, 255))};
    end
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic test_payload_extremes();
    send_text("2#", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_empty_and_no_digits();
    send_text("0#", 1'b0);
    send_byte(DIGIT_LO - 1'b1, 1'b1);
  endtask

  task automatic test_leading_zeros();
    send_text("01:q", 1'b1);
  endtask

  task automatic test_too_large();
    send_text("65536", 1'b0);
    send_text("x", 1'b1);
  endtask

  task automatic test_truncation();
    send_text("65535#", 1'b1);
    send_text("3#a", 1'b1);
  endtask

  task automatic test_random_messages(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = requests_sent + n_items;
    while (requests_sent < stop_at) begin
      send_random_message();
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_payload_extremes();
    test_empty_and_no_digits();
    test_leading_zeros();
    test_too_large();
    test_truncation();
    drain_results();
    test_random_messages(1500);
    drain_results();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_messages(400);
    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
